// ----- sv/b2d_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds the field widths, the character codes, the format select codes and the cell payload type.
// No dependencies.
package b2d_pkg;

  localparam int VAL_W          = 32;
  localparam int DIG_W          = 4;
  localparam int BCD_DIGITS     = 10;
  localparam int CHAR_W         = 6;
  localparam int DEF_MAX_DIGITS = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

  typedef enum logic [1:0] {
    CMD_W8   = 2'd0,
    CMD_W16  = 2'd1,
    CMD_W32  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef logic [BCD_DIGITS-1:0][DIG_W-1:0] bcd_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [VAL_W-1:0] value;
    bcd_t             bcd;
  } cell_t;

  function automatic logic [3:0] field_digits(input cmd_t cmd);
    logic [3:0] n;
    case (cmd)
      CMD_W8:  n = 4'd3;
      CMD_W16: n = 4'd5;
      CMD_W32: n = 4'd10;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/b2d_cell.sv -----
// One shift-and-add-3 cell of the conversion chain.
// Takes one bit of the value into the BCD digits per cell. Depends on b2d_pkg.
module b2d_cell import b2d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cell_t d,
  output cell_t q
);

  logic  valid_r;
  cell_t pay_r;
  cell_t pay_nxt;
  bcd_t  adj;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (d.bcd[k] >= 4'd5) ? d.bcd[k] + 4'd3 : d.bcd[k];
    end
    pay_nxt       = d;
    pay_nxt.value = {d.value[VAL_W-2:0], 1'b0};
    pay_nxt.bcd[0] = {adj[0][DIG_W-2:0], d.value[VAL_W-1]};
    for (int k = 1; k < BCD_DIGITS; k++) begin
      pay_nxt.bcd[k] = {adj[k][DIG_W-2:0], adj[k-1][DIG_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r <= pay_nxt;
    end
  end

  always_comb begin
    q       = pay_r;
    q.valid = valid_r;
  end

endmodule

// ----- sv/b2d_ser.sv -----
// Character serializer: loads the finished BCD digits and sends one character per transfer.
// Blanks leading zeros, keeps the units digit. Depends on b2d_pkg.
module b2d_ser import b2d_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_t             cell_i,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last_char
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic                                valid_r, valid_nxt;
  logic [CW-1:0]                       left_r, left_nxt;
  logic                                seen_r, seen_nxt;
  logic [MAX_DIGITS-1:0][DIG_W-1:0]    digs_r, digs_nxt, digs_ld;
  logic [DIG_W-1:0]                    top;
  logic [3:0]                          n_full;
  logic [CW-1:0]                       n;
  logic                                seen_ld;
  logic                                xfer;
  logic                                fin;
  logic                                load;

  assign top  = digs_r[MAX_DIGITS-1];
  assign xfer = valid_r && !out_stall;
  assign fin  = xfer && (left_r == CW'(1));
  assign load_ok = !valid_r || fin;
  assign load = load_ok && cell_i.valid;

  assign n_full = field_digits(cell_i.cmd);
  assign n = (int'(n_full) > MAX_DIGITS) ? CW'(MAX_DIGITS) : CW'(n_full);

  always_comb begin
    seen_ld = 1'b0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      digs_ld[j] = '0;
      for (int p = 0; p < BCD_DIGITS; p++) begin
        if (p == j + int'(n) - MAX_DIGITS) begin
          digs_ld[j] = cell_i.bcd[p];
        end
      end
    end
    for (int p = 0; p < BCD_DIGITS; p++) begin
      if (p >= int'(n) && cell_i.bcd[p] != '0) begin
        seen_ld = 1'b1;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    left_nxt  = left_r;
    seen_nxt  = seen_r;
    digs_nxt  = digs_r;
    if (load) begin
      valid_nxt = 1'b1;
      left_nxt  = n;
      seen_nxt  = seen_ld;
      digs_nxt  = digs_ld;
    end else if (xfer) begin
      valid_nxt = !fin;
      left_nxt  = left_r - CW'(1);
      seen_nxt  = seen_r || (top != '0);
      digs_nxt[0] = '0;
      for (int j = 1; j < MAX_DIGITS; j++) begin
        digs_nxt[j] = digs_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    seen_r <= seen_nxt;
    digs_r <= digs_nxt;
  end

  assign out_valid     = valid_r;
  assign out_last_char = (left_r == CW'(1));
  assign out_character = (seen_r || top != '0 || left_r == CW'(1)) ?
                         CHAR_ZERO + CHAR_W'(top) : CHAR_SPACE;

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (left_r != '0 && int'(left_r) <= MAX_DIGITS))
    else $error("character count out of range");

  a_units_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_last_char) |-> (out_character != CHAR_SPACE))
    else $error("units position blanked");

  a_no_space_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !out_last_char && out_character != CHAR_SPACE) |=>
    (out_character != CHAR_SPACE))
    else $error("space after a digit");

  a_mid_field_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !out_last_char) |=> valid_r)
    else $error("field ended early");

endmodule

// ----- sv/binary_to_decimal_ascii.sv -----
// Binary to right-justified decimal ASCII converter, top level.
// Input passes through the 32 cells, then the serializer, before the first character.
// Throughput: 3, 5 or 10 characters per item, one per cycle unless out_stall; the
// serializer sets input pace, the chain takes a new item every cycle while it has room.
// Reset clears the valid bits of the chain and serializer; select code 3 gives no output.
// Depends on b2d_pkg, b2d_cell, b2d_ser.
module binary_to_decimal_ascii import b2d_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last_char
);

  cell_t            chain [VAL_W+1];
  logic             adv;
  logic             load_ok;
  logic [VAL_W-1:0] aligned;

  always_comb begin
    case (cmd_t'(in_cmd))
      CMD_W8:  aligned = {24'd0, in_value[7:0]};
      CMD_W16: aligned = {16'd0, in_value[15:0]};
      default: aligned = in_value;
    endcase
  end

  always_comb begin
    chain[0].valid = in_valid && (cmd_t'(in_cmd) != CMD_NONE);
    chain[0].cmd   = cmd_t'(in_cmd);
    chain[0].value = aligned;
    chain[0].bcd   = '0;
  end

  assign adv      = !chain[VAL_W].valid || load_ok;
  assign in_stall = !adv;

  for (genvar i = 0; i < VAL_W; i++) begin : g_cell
    b2d_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .d    (chain[i]),
      .q    (chain[i+1])
    );
  end

  b2d_ser #(.MAX_DIGITS(MAX_DIGITS)) u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_i       (chain[VAL_W]),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last_char(out_last_char)
  );

endmodule
